// ===== hw/rtl/ppa_pkg.sv =====
// Package for the physical page allocator: sizes, codes and the command and
// status structs that join the controller and the datapath.
// Depends on nothing.
`default_nettype none

package ppa_pkg;

    // Sizing constants.
    localparam int MAX_REGIONS = 16;
    localparam int FREE_DEPTH  = 1024;
    localparam int PAGE_BYTES  = 4096;
    localparam int ADDR_BITS   = 48;
    localparam int PAGE_BITS   = 36;
    localparam int KIND_BITS   = 32;
    localparam int CFG_IDX_BITS = 1;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    // Region bounds are kept wider than a page number so that rounding up
    // and region ends cannot wrap.
    localparam int RP_W = ADDR_BITS - PAGE_SHIFT + 1;
    localparam int RF_W = (RP_W + 1 > PAGE_BITS + 1) ? RP_W + 1 : PAGE_BITS + 1;

    localparam int RG_AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int RG_CW = $clog2(MAX_REGIONS + 1);
    localparam int FD_AW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int FD_CW = $clog2(FREE_DEPTH + 1);

    localparam logic [KIND_BITS-1:0] USABLE_KIND = KIND_BITS'(1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_FIRST = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_LAST  = CFG_IDX_BITS'(1);

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_RESERVE = 2'd2,
        ACT_ADD     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OOM      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_REJECT   = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        GRANT_NONE  = 2'd0,
        GRANT_STACK = 2'd1,
        GRANT_HEAD  = 2'd2
    } grant_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       latch;
        logic       pop_rd;
        logic       push;
        logic       head_take;
        logic       add_calc;
        logic       add_commit;
        logic       scan_cap;
        logic       scan_next;
        logic       split;
        logic       stk_init;
        logic       stk_rd;
        logic       stk_dec;
        logic       shift_rd;
        logic       shift_wr;
        logic       cnt_dec;
        logic       finish;
        status_t    code;
        grant_sel_t grant_sel;
    } ppa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic freed_empty;
        logic freed_full;
        logic region_empty;
        logic region_full;
        logic add_reject;
        logic scan_end;
        logic scan_hit;
        logic split_two;
        logic stk_hit;
        logic sp_zero;
        logic shift_end;
    } ppa_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/physical_page_allocator.sv =====
// Top level of the physical page allocator: joins the controller and the
// datapath. Depends on ppa_pkg, ppa_ctrl and ppa_dpath.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  request   | start, busy          | action, page_number, region_base,
//            |                      | region_length, region_kind
//  result    | done (one cycle)     | granted_page, status
//  config    | cfg_we               | cfg_index, cfg_data
//
// A request is taken when start is high and busy is low; its result shows
// in the cycle after the controller finishes. Reserve scans the region
// table entry by entry; if no region holds the page, it compares the freed
// page stack entries from the top and moves the entries above a match down,
// as the stack memory is read and written one entry at a time.
// Reset is asynchronous and empties both tables. The receiver cannot stall.
`default_nettype none

module physical_page_allocator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       action,
    input  wire logic [ppa_pkg::PAGE_BITS-1:0]    page_number,
    input  wire logic [ppa_pkg::ADDR_BITS-1:0]    region_base,
    input  wire logic [ppa_pkg::ADDR_BITS-1:0]    region_length,
    input  wire logic [ppa_pkg::KIND_BITS-1:0]    region_kind,
    output logic                                  done,
    output logic [ppa_pkg::PAGE_BITS-1:0]         granted_page,
    output logic [2:0]                            status,
    input  wire logic                             cfg_we,
    input  wire logic [ppa_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [ppa_pkg::ADDR_BITS-1:0]    cfg_data
);
    import ppa_pkg::*;

    ppa_cmd_t  cmd;
    ppa_stat_t stat;

    // Sequencer.
    ppa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Tables, arithmetic and results.
    ppa_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .page_number   (page_number),
        .region_base   (region_base),
        .region_length (region_length),
        .region_kind   (region_kind),
        .cmd           (cmd),
        .stat          (stat),
        .granted_page  (granted_page),
        .status        (status),
        .done          (done)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ppa_ctrl.sv =====
// Controller of the page allocator: one state machine that sequences each
// request through the datapath. Depends on ppa_pkg.
`default_nettype none

module ppa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        action,
    input  wire ppa_pkg::ppa_stat_t stat,
    output ppa_pkg::ppa_cmd_t      cmd,
    output logic                   busy
);
    import ppa_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_ALLOC   = 12'b0000_0000_0010,
        S_POP     = 12'b0000_0000_0100,
        S_FREE    = 12'b0000_0000_1000,
        S_ADD1    = 12'b0000_0001_0000,
        S_ADD2    = 12'b0000_0010_0000,
        S_SCAN    = 12'b0000_0100_0000,
        S_SPLIT   = 12'b0000_1000_0000,
        S_STK_RD  = 12'b0001_0000_0000,
        S_STK_CMP = 12'b0010_0000_0000,
        S_SH_CHK  = 12'b0100_0000_0000,
        S_SH_WR   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.code = ST_OK;
        cmd.grant_sel = GRANT_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    case (action_t'(action))
                        ACT_ALLOC:   state_next = S_ALLOC;
                        ACT_FREE:    state_next = S_FREE;
                        ACT_RESERVE: state_next = S_SCAN;
                        ACT_ADD:     state_next = S_ADD1;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (!stat.freed_empty)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP;
                end
                else if (!stat.region_empty)
                begin
                    cmd.head_take = 1'b1;
                    cmd.finish = 1'b1;
                    cmd.grant_sel = GRANT_HEAD;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.code = ST_OOM;
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                cmd.finish = 1'b1;
                cmd.grant_sel = GRANT_STACK;
                state_next = S_IDLE;
            end
            S_FREE:
            begin
                cmd.finish = 1'b1;
                if (stat.freed_full)
                begin
                    cmd.code = ST_FULL;
                end
                else
                begin
                    cmd.push = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_ADD1:
            begin
                cmd.add_calc = 1'b1;
                state_next = S_ADD2;
            end
            S_ADD2:
            begin
                cmd.finish = 1'b1;
                if (stat.add_reject)
                begin
                    cmd.code = ST_REJECT;
                end
                else if (stat.region_full)
                begin
                    cmd.code = ST_FULL;
                end
                else
                begin
                    cmd.add_commit = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_cap = 1'b1;
                if (stat.scan_end)
                begin
                    if (stat.freed_empty)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code = ST_NOTFOUND;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.stk_init = 1'b1;
                        state_next = S_STK_RD;
                    end
                end
                else if (stat.scan_hit)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_SPLIT:
            begin
                cmd.finish = 1'b1;
                if (stat.split_two && stat.region_full)
                begin
                    cmd.code = ST_FULL;
                end
                else
                begin
                    cmd.split = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_STK_RD:
            begin
                cmd.stk_rd = 1'b1;
                state_next = S_STK_CMP;
            end
            S_STK_CMP:
            begin
                if (stat.stk_hit)
                begin
                    state_next = S_SH_CHK;
                end
                else if (stat.sp_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.code = ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.stk_dec = 1'b1;
                    state_next = S_STK_RD;
                end
            end
            S_SH_CHK:
            begin
                if (stat.shift_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next = S_SH_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ppa_dpath.sv =====
// Datapath of the page allocator: kernel range registers, the region table,
// the freed page stack memory, add-region arithmetic and result registers.
// Depends on ppa_pkg.
`default_nettype none

module ppa_dpath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [ppa_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [ppa_pkg::ADDR_BITS-1:0]        cfg_data,
    input  wire logic [ppa_pkg::PAGE_BITS-1:0]        page_number,
    input  wire logic [ppa_pkg::ADDR_BITS-1:0]        region_base,
    input  wire logic [ppa_pkg::ADDR_BITS-1:0]        region_length,
    input  wire logic [ppa_pkg::KIND_BITS-1:0]        region_kind,
    input  wire ppa_pkg::ppa_cmd_t                    cmd,
    output ppa_pkg::ppa_stat_t                        stat,
    output logic [ppa_pkg::PAGE_BITS-1:0]             granted_page,
    output logic [2:0]                                status,
    output logic                                      done
);
    import ppa_pkg::*;

    // Configuration registers.
    logic [ADDR_BITS-1:0] kfirst_reg;
    logic [ADDR_BITS-1:0] klast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kfirst_reg <= '0;
            klast_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_KERNEL_FIRST)
            begin
                kfirst_reg <= cfg_data;
            end
            if (cfg_index == REG_KERNEL_LAST)
            begin
                klast_reg <= cfg_data;
            end
        end
    end

    // Request fields captured at acceptance.
    logic [PAGE_BITS-1:0] pg_reg;
    logic [ADDR_BITS-1:0] base_reg;
    logic [ADDR_BITS-1:0] len_reg;
    logic [KIND_BITS-1:0] kind_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            pg_reg   <= page_number;
            base_reg <= region_base;
            len_reg  <= region_length;
            kind_reg <= region_kind;
        end
    end

    logic [RF_W-1:0] pg_ext;
    assign pg_ext = RF_W'(pg_reg);

    // Add-region stage one: round the base up and the length down.
    logic [PAGE_SHIFT-1:0] rem;
    logic                  rem_nz;
    logic [PAGE_SHIFT:0]   adj;
    logic [ADDR_BITS-1:0]  len_adj;
    logic [RF_W-1:0]       add_first_reg;
    logic [RP_W-1:0]       add_pages_reg;
    logic                  add_bad_reg;

    assign rem     = base_reg[PAGE_SHIFT-1:0];
    assign rem_nz  = (rem != '0);
    assign adj     = rem_nz ? ((PAGE_SHIFT + 1)'(PAGE_BYTES) - {1'b0, rem}) : '0;
    assign len_adj = len_reg - ADDR_BITS'(adj);

    always_ff @(posedge clk)
    begin
        if (cmd.add_calc)
        begin
            add_first_reg <= RF_W'(base_reg >> PAGE_SHIFT) + RF_W'(rem_nz);
            add_pages_reg <= RP_W'(len_adj >> PAGE_SHIFT);
            add_bad_reg   <= (kind_reg != USABLE_KIND) || (len_reg < ADDR_BITS'(adj));
        end
    end

    // Add-region stage two: kernel overlap check.
    logic [RF_W-1:0] add_end;
    logic [RF_W-1:0] kf_ceil;
    logic [RF_W-1:0] kl_page;
    logic            add_below;
    logic            add_above;

    assign add_end   = add_first_reg + RF_W'(add_pages_reg);
    assign kf_ceil   = RF_W'(kfirst_reg >> PAGE_SHIFT)
                     + RF_W'(kfirst_reg[PAGE_SHIFT-1:0] != '0);
    assign kl_page   = RF_W'(klast_reg >> PAGE_SHIFT);
    assign add_below = (add_end < kf_ceil);
    assign add_above = (add_first_reg > kl_page);

    // Region table: a row of entries, head at index zero.
    logic [RF_W-1:0]  rg_first_reg [MAX_REGIONS];
    logic [RP_W-1:0]  rg_pages_reg [MAX_REGIONS];
    logic [RG_CW-1:0] rg_count_reg;
    logic [RG_CW-1:0] idx_reg;
    logic [RP_W-1:0]  lo_reg;
    logic [RP_W-1:0]  hi_reg;

    logic [RG_AW-1:0] sidx;
    logic [RF_W-1:0]  sel_first;
    logic [RP_W-1:0]  sel_pages;
    logic [RF_W-1:0]  sel_off;
    logic             scan_hit;
    logic             head_last;
    logic             lo_nz;
    logic             hi_nz;

    assign sidx      = idx_reg[RG_AW-1:0];
    assign sel_first = rg_first_reg[sidx];
    assign sel_pages = rg_pages_reg[sidx];
    assign sel_off   = pg_ext - sel_first;
    assign scan_hit  = (sel_first <= pg_ext) && (sel_off < RF_W'(sel_pages));
    assign head_last = (rg_pages_reg[0] == RP_W'(1));
    assign lo_nz     = (lo_reg != '0);
    assign hi_nz     = (hi_reg != '0);

    // Scan index and captured split pieces.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.latch)
        begin
            idx_reg <= '0;
        end
        else if (cmd.scan_next)
        begin
            idx_reg <= idx_reg + RG_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_cap)
        begin
            lo_reg <= RP_W'(sel_off);
            hi_reg <= sel_pages - RP_W'(sel_off) - RP_W'(1);
        end
    end

    // Region count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rg_count_reg <= '0;
        end
        else if (cmd.add_commit)
        begin
            rg_count_reg <= rg_count_reg + RG_CW'(1);
        end
        else if (cmd.head_take && head_last)
        begin
            rg_count_reg <= rg_count_reg - RG_CW'(1);
        end
        else if (cmd.split && lo_nz && hi_nz)
        begin
            rg_count_reg <= rg_count_reg + RG_CW'(1);
        end
        else if (cmd.split && !lo_nz && !hi_nz)
        begin
            rg_count_reg <= rg_count_reg - RG_CW'(1);
        end
    end

    // Each table entry holds, shifts from a neighbor, or loads a new or trimmed value.
    for (genvar g = 0; g < MAX_REGIONS; g++)
    begin : g_entry
        localparam int PREV = (g > 0) ? g - 1 : 0;
        localparam int NEXT = (g < MAX_REGIONS - 1) ? g + 1 : g;

        always_ff @(posedge clk)
        begin
            if (cmd.add_commit)
            begin
                if (g == 0)
                begin
                    rg_first_reg[g] <= add_first_reg;
                    rg_pages_reg[g] <= add_pages_reg;
                end
                else
                begin
                    rg_first_reg[g] <= rg_first_reg[PREV];
                    rg_pages_reg[g] <= rg_pages_reg[PREV];
                end
            end
            else if (cmd.head_take)
            begin
                if (head_last)
                begin
                    rg_first_reg[g] <= rg_first_reg[NEXT];
                    rg_pages_reg[g] <= rg_pages_reg[NEXT];
                end
                else if (g == 0)
                begin
                    rg_first_reg[g] <= rg_first_reg[g] + RF_W'(1);
                    rg_pages_reg[g] <= rg_pages_reg[g] - RP_W'(1);
                end
            end
            else if (cmd.split)
            begin
                if (lo_nz && hi_nz)
                begin
                    // Lower piece stays, upper piece is inserted behind it.
                    if (g == int'(sidx))
                    begin
                        rg_pages_reg[g] <= lo_reg;
                    end
                    else if (g == int'(sidx) + 1)
                    begin
                        rg_first_reg[g] <= pg_ext + RF_W'(1);
                        rg_pages_reg[g] <= hi_reg;
                    end
                    else if (g > int'(sidx) + 1)
                    begin
                        rg_first_reg[g] <= rg_first_reg[PREV];
                        rg_pages_reg[g] <= rg_pages_reg[PREV];
                    end
                end
                else if (lo_nz)
                begin
                    if (g == int'(sidx))
                    begin
                        rg_pages_reg[g] <= lo_reg;
                    end
                end
                else if (hi_nz)
                begin
                    if (g == int'(sidx))
                    begin
                        rg_first_reg[g] <= pg_ext + RF_W'(1);
                        rg_pages_reg[g] <= hi_reg;
                    end
                end
                else if (g >= int'(sidx))
                begin
                    // Single-page region drained: close the gap.
                    rg_first_reg[g] <= rg_first_reg[NEXT];
                    rg_pages_reg[g] <= rg_pages_reg[NEXT];
                end
            end
        end
    end

    // Freed page stack: memory, count and search pointer.
    logic [PAGE_BITS-1:0] fs_mem [FREE_DEPTH];
    logic [PAGE_BITS-1:0] rdata_reg;
    logic [FD_CW-1:0]     fs_count_reg;
    logic [FD_AW-1:0]     sp_reg;
    logic [FD_CW-1:0]     count_m1;
    logic [FD_AW-1:0]     rd_addr;
    logic                 rd_en;
    logic [FD_AW-1:0]     wr_addr;
    logic [PAGE_BITS-1:0] wr_data;
    logic                 wr_en;

    assign count_m1 = fs_count_reg - FD_CW'(1);

    always_comb
    begin
        rd_en   = cmd.pop_rd || cmd.stk_rd || cmd.shift_rd;
        rd_addr = sp_reg;
        if (cmd.pop_rd)
        begin
            rd_addr = count_m1[FD_AW-1:0];
        end
        else if (cmd.shift_rd)
        begin
            rd_addr = sp_reg + FD_AW'(1);
        end
        wr_en   = cmd.push || cmd.shift_wr;
        wr_addr = cmd.push ? fs_count_reg[FD_AW-1:0] : sp_reg;
        wr_data = cmd.push ? pg_reg : rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fs_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= fs_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_count_reg <= '0;
        end
        else if (cmd.push)
        begin
            fs_count_reg <= fs_count_reg + FD_CW'(1);
        end
        else if (cmd.pop_rd || cmd.cnt_dec)
        begin
            fs_count_reg <= count_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else if (cmd.stk_init)
        begin
            sp_reg <= count_m1[FD_AW-1:0];
        end
        else if (cmd.stk_dec)
        begin
            sp_reg <= sp_reg - FD_AW'(1);
        end
        else if (cmd.shift_wr)
        begin
            sp_reg <= sp_reg + FD_AW'(1);
        end
    end

    // Status toward the controller.
    always_comb
    begin
        stat.freed_empty  = (fs_count_reg == '0);
        stat.freed_full   = (fs_count_reg == FD_CW'(FREE_DEPTH));
        stat.region_empty = (rg_count_reg == '0);
        stat.region_full  = (rg_count_reg == RG_CW'(MAX_REGIONS));
        stat.add_reject   = add_bad_reg || (add_pages_reg == '0) || !(add_below || add_above);
        stat.scan_end     = (idx_reg == rg_count_reg);
        stat.scan_hit     = scan_hit;
        stat.split_two    = lo_nz && hi_nz;
        stat.stk_hit      = (rdata_reg == pg_reg);
        stat.sp_zero      = (sp_reg == '0);
        stat.shift_end    = ((FD_CW'(sp_reg) + FD_CW'(1)) == fs_count_reg);
    end

    // Result registers.
    logic [PAGE_BITS-1:0] granted_reg;
    logic [2:0]           status_reg;
    logic                 done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            status_reg  <= '0;
            granted_reg <= '0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                status_reg <= cmd.code;
                case (cmd.grant_sel)
                    GRANT_STACK: granted_reg <= rdata_reg;
                    GRANT_HEAD:  granted_reg <= rg_first_reg[0][PAGE_BITS-1:0];
                    default:     granted_reg <= '0;
                endcase
            end
        end
    end

    assign granted_page = granted_reg;
    assign status       = status_reg;
    assign done         = done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ppa_checker.sv =====
// Port-level checks of the page allocator and the bind that attaches them.
// Depends on ppa_pkg and physical_page_allocator.
`default_nettype none

module ppa_port_props (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic [ppa_pkg::PAGE_BITS-1:0] granted_page,
    input wire logic [2:0]                    status
);
    import ppa_pkg::*;

    // An accepted request always sets the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // Results are never shown back to back.
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    // When the block leaves busy, it shows a result.
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // Status codes stay within the defined set.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_OOM || status == ST_NOTFOUND ||
                  status == ST_REJECT || status == ST_FULL))
        else $error("undefined status code");

    // Only a successful request can carry a granted page.
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (granted_page == '0))
        else $error("page granted on a failed request");

endmodule

bind physical_page_allocator ppa_port_props u_ppa_port_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .granted_page (granted_page),
    .status       (status)
);

`default_nettype wire
